### src/mpjs_pkg.sv
// package for the multi-policy job scheduler
// holds sizes, action and policy codes, the sequencer state type and payload structs
// no dependencies
package mpjs_pkg;

	localparam int MaxJobsDefault = 16;
	localparam int SlotW = 4;
	localparam int TimeW = 32;
	localparam int ValW = 16;
	localparam int TickW = 33;
	localparam int SumW = 48;
	localparam int CntW = 16;
	localparam int PolW = 3;
	localparam int KeyW = 34;

	typedef enum logic [1:0] {
		ACT_ARRIVE = 2'd0,
		ACT_QUANTUM = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	localparam logic [PolW-1:0] POL_FCFS = 3'd0;
	localparam logic [PolW-1:0] POL_PRIO = 3'd1;
	localparam logic [PolW-1:0] POL_PPRIO = 3'd2;
	localparam logic [PolW-1:0] POL_SRT = 3'd3;
	localparam logic [PolW-1:0] POL_RR = 3'd4;
	localparam logic [PolW-1:0] POL_SJF = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [SlotW-1:0] job_slot;
		logic slot_present;
		logic [TimeW-1:0] event_time;
		logic [ValW-1:0] job_priority;
		logic [ValW-1:0] run_length;
	} req_t;

	typedef struct packed {
		logic next_valid;
		logic [SlotW-1:0] next_slot;
		logic signed [SumW-1:0] waiting_total;
		logic signed [SumW-1:0] turnaround_total;
		logic signed [SumW-1:0] response_total;
		logic [CntW-1:0] jobs_done;
	} rsp_t;

	// one table row; ticks are 33-bit signed, all ones means never ran
	typedef struct packed {
		logic [TimeW-1:0] arrival;
		logic [ValW-1:0] prio;
		logic [ValW-1:0] remaining;
		logic [ValW-1:0] total;
		logic [TickW-1:0] last_run;
		logic [TickW-1:0] first_start;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

endpackage

### src/mpjs_if.sv
// valid/ready channel interfaces for the scheduler
// depends on mpjs_pkg
interface mpjs_req_if import mpjs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mpjs_rsp_if import mpjs_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### src/mpjs_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module mpjs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### src/multi_policy_job_scheduler.sv
// multi-policy job scheduler: for each input beat the slot's row is read and updated, then row 0
// is fetched and a min scan takes one row per cycle through the ram's one read port before the
// result is presented; a kept job under a non-preemptive policy skips the scan. one item at a
// time: no new input beat is taken until the result has been taken. arst_n clears the used bits,
// totals, count and policy; the job table holds junk until a slot is written, and a row's
// contents are never used before that.
module multi_policy_job_scheduler import mpjs_pkg::*; #(
	parameter int MAX_JOBS = MaxJobsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [PolW-1:0] cfg_wdata,
	mpjs_req_if.sink req,
	mpjs_rsp_if.source rsp
);
	localparam int IdxW = $clog2(MAX_JOBS);
	localparam int CntW2 = $clog2(MAX_JOBS + 1);

	state_t state_q, state_d;
	logic [PolW-1:0] policy_q;
	req_t req_q;
	logic [MAX_JOBS-1:0] used_q;
	logic [SumW-1:0] sum_w_q, sum_t_q, sum_r_q;
	logic [CntW-1:0] done_q;
	logic [CntW2-1:0] scan_q;
	logic found_q;
	logic [IdxW-1:0] best_q;
	logic [KeyW-1:0] best_key_q;
	logic [TimeW-1:0] best_arr_q;
	logic keep_q;
	rsp_t rsp_q;

	logic we;
	logic [IdxW-1:0] waddr, raddr;
	entry_t wdata, rdata;

	mpjs_ram #(.Width(EntryW), .Depth(MAX_JOBS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// slot field may exceed the table at small MAX_JOBS
	logic ok;
	logic [IdxW-1:0] sidx;
	assign ok = {{(32-SlotW){1'b0}}, req_q.job_slot} < MAX_JOBS;
	assign sidx = ok ? IdxW'(req_q.job_slot) : '0;

	// primary key of the row being scanned, widened to a common width (sign-extended for rr, else zero-extended)
	logic [KeyW-1:0] key;
	always_comb begin
		case (policy_q)
			POL_PRIO, POL_PPRIO: key = KeyW'(rdata.prio);
			POL_SRT: key = KeyW'(rdata.remaining);
			POL_RR: key = {rdata.last_run[TickW-1], rdata.last_run};
			POL_SJF: key = KeyW'(rdata.total);
			default: key = KeyW'(rdata.arrival);
		endcase
	end

	// the shared compare unit
	logic better;
	assign better = !found_q || ($signed(key) < $signed(best_key_q)) ||
		(key == best_key_q && rdata.arrival < best_arr_q);

	logic [CntW2-1:0] rd_idx;
	logic [IdxW-1:0] cur;
	assign rd_idx = scan_q - CntW2'(1);
	assign cur = rd_idx[IdxW-1:0];

	entry_t upd;
	logic [SumW-1:0] w_v, t_v, r_v;
	always_comb begin
		upd = rdata;
		if (rdata.first_start[TickW-1]) begin
			upd.first_start = TickW'(req_q.event_time) - TickW'(1);
		end
		upd.last_run = TickW'(req_q.event_time);
		if (rdata.remaining != '0) begin
			upd.remaining = rdata.remaining - ValW'(1);
		end
		t_v = SumW'(req_q.event_time) - SumW'(rdata.arrival);
		w_v = t_v - SumW'(rdata.total);
		r_v = {{(SumW-TickW){rdata.first_start[TickW-1]}}, rdata.first_start}
			- SumW'(rdata.arrival);
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = sidx;
		wdata = upd;
		raddr = sidx;
		req.ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: if (req.valid) state_d = ST_READ;
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (req_q.action == ACT_ARRIVE && ok) begin
					we = 1'b1;
					wdata.arrival = req_q.event_time;
					wdata.prio = req_q.job_priority;
					wdata.total = req_q.run_length;
					wdata.remaining = req_q.run_length;
					wdata.last_run = '1;
					wdata.first_start = '1;
				end else if (req_q.action == ACT_QUANTUM && req_q.slot_present && ok
						&& used_q[sidx]) begin
					we = 1'b1;
				end
				raddr = '0;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				raddr = (scan_q < CntW2'(MAX_JOBS)) ? scan_q[IdxW-1:0] : '0;
				if (keep_q || scan_q == CntW2'(MAX_JOBS)) state_d = ST_DONE;
			end
			ST_DONE: if (rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			policy_q <= POL_FCFS;
			used_q <= '0;
			sum_w_q <= '0;
			sum_t_q <= '0;
			sum_r_q <= '0;
			done_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) policy_q <= cfg_wdata;
			if (state_q == ST_UPDATE && ok) begin
				if (req_q.action == ACT_ARRIVE) begin
					used_q[sidx] <= 1'b1;
				end else if (req_q.action == ACT_FINISH && used_q[sidx]) begin
					used_q[sidx] <= 1'b0;
					sum_w_q <= sum_w_q + w_v;
					sum_t_q <= sum_t_q + t_v;
					sum_r_q <= sum_r_q + r_v;
					done_q <= done_q + CntW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) req_q <= req.data;
		if (state_q == ST_UPDATE) begin
			// first scan cycle only fetches row 0, after the update write has landed
			scan_q <= '0;
			found_q <= 1'b0;
			keep_q <= req_q.action == ACT_QUANTUM && req_q.slot_present && ok
				&& used_q[sidx] && !(policy_q == POL_PPRIO || policy_q == POL_SRT
				|| policy_q == POL_RR);
		end
		if (state_q == ST_SCAN && !keep_q) begin
			scan_q <= scan_q + CntW2'(1);
			if (scan_q != '0 && used_q[cur] && better) begin
				found_q <= 1'b1;
				best_q <= cur;
				best_key_q <= key;
				best_arr_q <= rdata.arrival;
			end
		end
		if (state_q == ST_SCAN && state_d == ST_DONE) begin
			rsp_q.waiting_total <= sum_w_q;
			rsp_q.turnaround_total <= sum_t_q;
			rsp_q.response_total <= sum_r_q;
			rsp_q.jobs_done <= done_q;
			if (keep_q) begin
				rsp_q.next_valid <= 1'b1;
				rsp_q.next_slot <= SlotW'(sidx);
			end else if (used_q[cur] && better) begin
				rsp_q.next_valid <= 1'b1;
				rsp_q.next_slot <= SlotW'(cur);
			end else begin
				rsp_q.next_valid <= found_q;
				rsp_q.next_slot <= found_q ? SlotW'(best_q) : '0;
			end
		end
	end

	assign rsp.valid = (state_q == ST_DONE);
	assign rsp.data = rsp_q;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("ready while busy");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
		else $error("result dropped");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPDATE) |=> $stable(done_q)) else $error("count moved");
`endif
endmodule

### tb/multi_policy_job_scheduler_tb.sv
// testbench for multi_policy_job_scheduler: random and directed scheduling events
// checked beat by beat against an in-bench scheduler model
// depends on mpjs_pkg, mpjs_req_if / mpjs_rsp_if and the scheduler rtl
module multi_policy_job_scheduler_tb;
	import mpjs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Jobs = 16;
	localparam int DrainCycles = 40;
	localparam int StallLimit = 3000;
	localparam int HoldCycles = 300;
	// codes beyond the named policies order like fcfs
	localparam logic [PolW-1:0] POL_ALT6 = 3'd6;
	localparam logic [PolW-1:0] POL_ALT7 = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [PolW-1:0] cfg_wdata;

	mpjs_req_if req_ch ();
	mpjs_rsp_if rsp_ch ();

	multi_policy_job_scheduler uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	// scheduler model state
	logic [PolW-1:0] sched_policy;
	bit job_used [Jobs];
	longint job_arrival [Jobs];
	longint job_prio [Jobs];
	longint job_remaining [Jobs];
	longint job_last_run [Jobs];
	longint job_total [Jobs];
	longint job_first_start [Jobs];
	logic [SumW-1:0] wait_sum, turn_sum, resp_sum;
	logic [CntW-1:0] done_count;

	req_t pending_events[$];
	rsp_t expected_picks[$];
	int mismatches;
	int beats_in;
	bit calm;
	bit req_took;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint order_key(int s);
		case (sched_policy)
			POL_PRIO, POL_PPRIO: return job_prio[s];
			POL_SRT: return job_remaining[s];
			POL_RR: return job_last_run[s];
			POL_SJF: return job_total[s];
			default: return job_arrival[s];
		endcase
	endfunction

	function automatic bit runs_first(int x, int y);
		longint kx, ky;
		kx = order_key(x);
		ky = order_key(y);
		if (kx != ky) return kx < ky;
		if (job_arrival[x] != job_arrival[y]) return job_arrival[x] < job_arrival[y];
		return x < y;
	endfunction

	function automatic rsp_t schedule_event(req_t ev);
		rsp_t r;
		int s;
		int best;
		bit found;
		longint t;
		s = ev.job_slot;
		t = longint'(ev.event_time);
		best = 0;
		found = 0;
		r = '0;
		if (ev.action == ACT_ARRIVE) begin
			job_used[s] = 1;
			job_arrival[s] = t;
			job_prio[s] = ev.job_priority;
			job_total[s] = ev.run_length;
			job_remaining[s] = ev.run_length;
			job_last_run[s] = -1;
			job_first_start[s] = -1;
		end else if (ev.action == ACT_FINISH && job_used[s]) begin
			wait_sum += SumW'(t - job_arrival[s] - job_total[s]);
			turn_sum += SumW'(t - job_arrival[s]);
			resp_sum += SumW'(job_first_start[s] - job_arrival[s]);
			done_count += CntW'(1);
			job_used[s] = 0;
		end
		if (ev.action == ACT_QUANTUM && ev.slot_present && job_used[s]) begin
			if (job_first_start[s] < 0) job_first_start[s] = t - 1;
			job_last_run[s] = t;
			if (job_remaining[s] > 0) job_remaining[s] -= 1;
			if (sched_policy != POL_PPRIO && sched_policy != POL_SRT && sched_policy != POL_RR) begin
				found = 1;
				best = s;
			end
		end
		if (!found) begin
			for (int i = 0; i < Jobs; i++) begin
				if (job_used[i] && (!found || runs_first(i, best))) begin
					best = i;
					found = 1;
				end
			end
		end
		r.next_valid = found;
		r.next_slot = found ? SlotW'(best) : '0;
		r.waiting_total = wait_sum;
		r.turnaround_total = turn_sum;
		r.response_total = resp_sum;
		r.jobs_done = done_count;
		return r;
	endfunction

	// driver: one assignment per signal per step
	always @(negedge clk) begin
		req_t nxt;
		bit show;
		show = 1'b0;
		nxt = req_ch.data;
		if (!req_ch.valid || req_took) begin
			if (pending_events.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
				nxt = pending_events.pop_front();
				show = 1'b1;
			end
		end else begin
			show = 1'b1;
		end
		req_ch.valid <= show;
		req_ch.data <= nxt;
	end

	// receiver, with one long hold-off once 500 input beats have been taken
	int hold_left;
	bit hold_done;
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && beats_in >= 500) begin
			hold_done <= 1'b1;
			hold_left <= HoldCycles;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= calm || $urandom_range(0, 99) >= 26;
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		rsp_t got, want;
		req_took <= req_ch.valid && req_ch.ready;
		if (cfg_we) sched_policy <= cfg_wdata;
		if (req_ch.valid && req_ch.ready) begin
			expected_picks.push_back(schedule_event(req_ch.data));
			beats_in <= beats_in + 1;
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (expected_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = expected_picks.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: valid %0b/%0b slot %0d/%0d", want.next_valid,
							got.next_valid, want.next_slot, got.next_slot);
						$display("  wait %0d/%0d turn %0d/%0d resp %0d/%0d done %0d/%0d",
							want.waiting_total, got.waiting_total, want.turnaround_total,
							got.turnaround_total, want.response_total, got.response_total,
							want.jobs_done, got.jobs_done);
					end
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	int quiet;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !arst_n) begin
			quiet <= 0;
		end else if (quiet >= StallLimit) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// stimulus shadow of the table, used to aim events at live slots
	bit live [Jobs];
	logic [TimeW-1:0] clock_now;

	function automatic req_t make_event();
		req_t ev;
		int pick;
		int sel;
		ev.action = ACT_ARRIVE;
		ev.job_slot = SlotW'($urandom_range(0, Jobs - 1));
		ev.slot_present = 1'b1;
		ev.job_priority = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		ev.run_length = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 8));
		clock_now += $urandom_range(0, 3);
		ev.event_time = ($urandom_range(0, 49) == 0) ? $urandom : clock_now;
		pick = $urandom_range(0, 99);
		sel = -1;
		for (int i = 0; i < Jobs; i++)
			if (live[i] && (sel < 0 || $urandom_range(0, 2) == 0)) sel = i;
		if (pick < 40) begin
			// mostly into a free slot
			if ($urandom_range(0, 4) != 0)
				for (int i = 0; i < Jobs; i++)
					if (!live[i] && $urandom_range(0, 1) == 0) ev.job_slot = SlotW'(i);
			live[ev.job_slot] = 1;
		end else if (pick < 75) begin
			ev.action = ACT_QUANTUM;
			if (sel >= 0 && $urandom_range(0, 9) != 0) ev.job_slot = SlotW'(sel);
			ev.slot_present = $urandom_range(0, 9) != 0;
		end else if (pick < 95) begin
			ev.action = ACT_FINISH;
			if (sel >= 0 && $urandom_range(0, 9) != 0) ev.job_slot = SlotW'(sel);
			live[ev.job_slot] = 0;
		end else begin
			ev.action = ACT_NONE;
			ev.slot_present = 1'($urandom);
		end
		return ev;
	endfunction

	function automatic req_t directed(action_t a, int slot, bit pres, logic [TimeW-1:0] t,
			logic [ValW-1:0] pr, logic [ValW-1:0] len);
		req_t ev;
		ev.action = a;
		ev.job_slot = SlotW'(slot);
		ev.slot_present = pres;
		ev.event_time = t;
		ev.job_priority = pr;
		ev.run_length = len;
		live[slot] = (a == ACT_ARRIVE) ? 1'b1 : (a == ACT_FINISH) ? 1'b0 : live[slot];
		return ev;
	endfunction

	task automatic drain();
		wait (pending_events.size() == 0);
		@(posedge clk);
		while (req_ch.valid || expected_picks.size() > 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic set_policy(logic [PolW-1:0] p);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = p;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		logic [PolW-1:0] plan [10];
		plan = '{POL_PRIO, POL_PPRIO, POL_SRT, POL_RR, POL_SJF, POL_ALT6, POL_ALT7,
			POL_FCFS, POL_RR, POL_PPRIO};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		calm = 1'b0;
		clock_now = 100;
		sched_policy = POL_FCFS;
		wait_sum = '0;
		turn_sum = '0;
		resp_sum = '0;
		done_count = '0;
		for (int i = 0; i < Jobs; i++) begin
			job_used[i] = 0;
			live[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, stale and free-slot events, never-run finish
		pending_events.push_back(directed(ACT_NONE, 0, 0, 0, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 3, 1, 5, 0, 1));
		pending_events.push_back(directed(ACT_FINISH, 7, 0, 6, 0, 1));
		pending_events.push_back(directed(ACT_ARRIVE, 15, 0, '1, '1, '1));
		pending_events.push_back(directed(ACT_ARRIVE, 0, 1, 0, 0, 1));
		pending_events.push_back(directed(ACT_ARRIVE, 5, 0, 0, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 5, 0, 1, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 0, 1, 0, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 0, 1, 1, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 0, 1, 2, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 9, 1, 3, 0, 1));
		pending_events.push_back(directed(ACT_FINISH, 15, 1, 4, 0, 1));
		pending_events.push_back(directed(ACT_ARRIVE, 5, 1, 7, 16'h8000, 16'h8000));
		pending_events.push_back(directed(ACT_FINISH, 0, 1, '1, 0, 1));
		pending_events.push_back(directed(ACT_NONE, 15, 1, '1, '1, '1));
		pending_events.push_back(directed(ACT_FINISH, 5, 0, 8, 0, 1));
		pending_events.push_back(directed(ACT_FINISH, 5, 0, 9, 0, 1));
		pending_events.push_back(directed(ACT_QUANTUM, 0, 0, 10, 0, 1));
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			set_policy(plan[ph]);
			calm = (ph == 4);
			for (int k = 0; k < 100; k++) pending_events.push_back(make_event());
			drain();
		end

		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
